@@ rtl/hedsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hedsc_pkg
// Shared constants, entity table and controller/datapath interface types
// for the HTML entity decoder with whitespace collapse.
// ----------------------------------------------------------------------------
package hedsc_pkg;

  // Entity window: '&' plus up to ENTITY_WINDOW-1 bytes ending with ';'
  localparam int ENTITY_WINDOW = 10;
  localparam int HOLD_DEPTH    = ENTITY_WINDOW - 1;
  localparam int CNT_W         = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W         = $clog2(HOLD_DEPTH);
  localparam int NUM_ENT       = 8;
  localparam int ENT_IDX_W     = 3;
  localparam int ENT_LEN_W     = 3;

  // Character codes
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted input word
    logic feed;        // run one decoder step on the selected byte
    logic src_replay;  // feed from the held bytes instead of the input word
    logic flush;       // pass one held byte literally at end of text
    logic finish;      // emit the closing result and return to reset state
  } hedsc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic done;        // current step has completed this cycle
    logic fail;        // current step ended an entity attempt without a match
    logic at_tail;     // rescan has reached the byte that ended the attempt
    logic flush_more;  // held bytes remain to be flushed
    logic out_free;    // output register can take a word this cycle
    logic last;        // the word being processed ends the text
  } hedsc_status_t;

  // Entity names after '&', first character in the lowest byte
  function automatic logic [31:0] ent_name(input logic [ENT_IDX_W-1:0] k);
    logic [31:0] nm;
    case (k)
      3'd0:    nm = {8'h00, "pma"};
      3'd1:    nm = "touq";
      3'd2:    nm = {16'h0000, "tl"};
      3'd3:    nm = {16'h0000, "tg"};
      3'd4:    nm = "sopa";
      3'd5:    nm = "72x#";
      3'd6:    nm = {8'h00, "93#"};
      default: nm = "psbn";
    endcase
    return nm;
  endfunction

  function automatic logic [ENT_LEN_W-1:0] ent_len(input logic [ENT_IDX_W-1:0] k);
    logic [ENT_LEN_W-1:0] ln;
    case (k)
      3'd0:    ln = 3'd3;
      3'd1:    ln = 3'd4;
      3'd2:    ln = 3'd2;
      3'd3:    ln = 3'd2;
      3'd4:    ln = 3'd4;
      3'd5:    ln = 3'd4;
      3'd6:    ln = 3'd3;
      default: ln = 3'd4;
    endcase
    return ln;
  endfunction

  function automatic logic [7:0] ent_val(input logic [ENT_IDX_W-1:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = CHAR_AMP;
      3'd1:    v = 8'h22;
      3'd2:    v = 8'h3C;
      3'd3:    v = 8'h3E;
      3'd4:    v = 8'h27;
      3'd5:    v = 8'h27;
      3'd6:    v = 8'h27;
      default: v = CHAR_SPACE;
    endcase
    return v;
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]});
  endfunction

endpackage

@@ rtl/html_entity_decode_space_collapse.sv @@
// ----------------------------------------------------------------------------
// html_entity_decode_space_collapse
// Decodes the entities amp, quot, lt, gt, apos, #x27, #39 and nbsp in a
// text byte stream and collapses whitespace runs to single spaces.
//
//   channel   dir  tdata          tuser      tlast
//   s_axis    in   in_byte[7:0]   -          in_last
//   m_axis    out  out_byte[7:0]  out_valid  out_last
//
// A plain byte is captured, then passes one decode step. A collapsed
// space ahead of a byte is sent as its own step. A failed entity rescans
// its bytes (up to nine) in turn over the single hold buffer port.
// The final word of a text is followed by a flush of the bytes still held
// and the close. Reset clears the decoder; a stalled m_axis holds the
// output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module html_entity_decode_space_collapse
  import hedsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_valid
  output logic       m_axis_tlast_o
);

  hedsc_cmd_t    cmd;
  hedsc_status_t status;

  // Sequencer
  hedsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Decoder datapath and output register
  hedsc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .out_ready_i  (m_axis_tready_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_byte_o   (m_axis_tdata_o),
    .out_flag_o   (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

@@ rtl/hedsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hedsc_ctrl
// Sequencer for the entity decoder: accepts a word, runs the decode step,
// sequences the rescan of held bytes, the end-of-text flush and the close.
// ----------------------------------------------------------------------------
module hedsc_ctrl
  import hedsc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output hedsc_cmd_t    cmd_o,
  input  hedsc_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_REPLAY,
    ST_FLUSH,
    ST_END
  } state_e;

  state_e state_q, state_d;

  // Take a new word only when idle
  assign in_ready_o = (state_q == ST_IDLE);

  // Commands per state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_FEED:   cmd_o.feed = 1'b1;
      ST_REPLAY: begin
        cmd_o.feed       = 1'b1;
        cmd_o.src_replay = 1'b1;
      end
      ST_FLUSH:  cmd_o.flush  = status_i.flush_more;
      ST_END:    cmd_o.finish = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FEED;
      end
      ST_FEED: begin
        if (status_i.done) begin
          if (status_i.fail)      state_d = ST_REPLAY;
          else if (status_i.last) state_d = ST_FLUSH;
          else                    state_d = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        if (status_i.done && !status_i.fail && status_i.at_tail) begin
          state_d = status_i.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!status_i.flush_more) state_d = ST_END;
      end
      ST_END: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/hedsc_datapath.sv @@
// ----------------------------------------------------------------------------
// hedsc_datapath
// Hold buffer, entity match mask, rescan pointers, whitespace collapse
// flags, end-of-text staging word and the output register.
// ----------------------------------------------------------------------------
module hedsc_datapath
  import hedsc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          out_ready_i,
  input  hedsc_cmd_t    cmd_i,
  output hedsc_status_t status_o,
  output logic          out_tvalid_o,
  output logic [7:0]    out_byte_o,
  output logic          out_flag_o,
  output logic          out_last_o
);

  // Storage
  logic [7:0]         hold_q [HOLD_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rp_q, rp_d;
  logic [CNT_W-1:0]   rend_q, rend_d;
  logic [NUM_ENT-1:0] match_q, match_d;
  logic [7:0]         work_q, tail_q, stage_b_q;
  logic               last_q;
  logic               lws_q, lws_d;
  logic               sp_q, sp_d;
  logic               stage_v_q, stage_v_d;
  logic               ov_q;
  logic [7:0]         ob_q;
  logic               of_q, ol_q;

  // Step signals
  logic               out_free, push_ok, at_tail, flush_more;
  logic [7:0]         rd_byte, src;
  logic [CNT_W-1:0]   pos;
  logic [NUM_ENT-1:0] keep, hit;
  logic               hit_any;
  logic [7:0]         hit_val;
  logic               fd_open, fd_append, fd_hit, fd_fail, fd_plain;
  logic               col_en, c_ws, col_done, push, done;
  logic [7:0]         col_byte, push_byte;
  logic               hold_we;
  logic [CNT_W-1:0]   hold_wa;
  logic [7:0]         hold_wd;
  logic               out_load;
  logic [7:0]         out_b_d;
  logic               out_f_d, out_l_d;

  assign out_free   = !ov_q || out_ready_i;
  assign push_ok    = last_q ? (!stage_v_q || out_free) : out_free;
  assign at_tail    = (rp_q >= rend_q);
  assign flush_more = (rp_q < cnt_q);

  // Single read port on the hold buffer (rescan and flush never overlap)
  assign rd_byte = (rp_q < CNT_W'(HOLD_DEPTH)) ? hold_q[rp_q[IDX_W-1:0]] : CHAR_NUL;
  assign src     = cmd_i.src_replay ? (at_tail ? tail_q : rd_byte) : work_q;

  // Narrow the candidate entities by the byte at the current name position
  assign pos = cnt_q - CNT_W'(1);

  always_comb begin
    logic [31:0]      nm;
    logic [CNT_W-1:0] ln;
    keep    = '0;
    hit     = '0;
    hit_val = CHAR_NUL;
    for (int k = 0; k < NUM_ENT; k++) begin
      nm      = ent_name(ENT_IDX_W'(k));
      ln      = CNT_W'(ent_len(ENT_IDX_W'(k)));
      keep[k] = match_q[k] && (pos < ln) && (nm[{pos[1:0], 3'b000} +: 8] == src);
      hit[k]  = match_q[k] && (ln == pos);
      if (hit[k]) hit_val = ent_val(ENT_IDX_W'(k));
    end
  end

  assign hit_any = |hit;

  // Classify the decoder step
  always_comb begin
    fd_open   = 1'b0;
    fd_append = 1'b0;
    fd_hit    = 1'b0;
    fd_fail   = 1'b0;
    fd_plain  = 1'b0;
    if (cnt_q == '0) begin
      if (src == CHAR_AMP) fd_open  = 1'b1;
      else                 fd_plain = 1'b1;
    end else if (src == CHAR_SEMI) begin
      if (hit_any) fd_hit  = 1'b1;
      else         fd_fail = 1'b1;
    end else if (cnt_q >= CNT_W'(HOLD_DEPTH)) begin
      fd_fail = 1'b1;
    end else begin
      fd_append = 1'b1;
    end
  end

  // Select the byte for the whitespace stage
  always_comb begin
    col_en   = 1'b0;
    col_byte = CHAR_NUL;
    if (cmd_i.flush) begin
      col_en   = flush_more;
      col_byte = rd_byte;
    end else if (cmd_i.feed) begin
      col_en   = fd_plain || fd_hit || fd_fail;
      col_byte = fd_plain ? src : (fd_hit ? hit_val : CHAR_AMP);
    end
  end

  // Whitespace collapse: a pending space goes out ahead of its byte
  assign c_ws      = is_ws(col_byte);
  assign push      = col_en && !c_ws && push_ok;
  assign push_byte = sp_q ? CHAR_SPACE : col_byte;
  assign col_done  = !col_en || c_ws || (!sp_q && push_ok);
  assign done      = (cmd_i.feed || cmd_i.flush) ? col_done : 1'b1;

  // Next state of the decoder
  always_comb begin
    cnt_d     = cnt_q;
    rp_d      = rp_q;
    rend_d    = rend_q;
    match_d   = match_q;
    lws_d     = lws_q;
    sp_d      = sp_q;
    stage_v_d = stage_v_q;
    hold_we   = 1'b0;
    hold_wa   = cnt_q;
    hold_wd   = src;
    out_load  = 1'b0;
    out_b_d   = push_byte;
    out_f_d   = 1'b1;
    out_l_d   = 1'b0;

    if (cmd_i.load) rp_d = '0;

    // Collapse flags
    if (col_en && c_ws && !lws_q) begin
      sp_d  = 1'b1;
      lws_d = 1'b1;
    end
    if (push) begin
      if (sp_q) sp_d  = 1'b0;
      else      lws_d = 1'b0;
    end

    // Route a produced byte: direct, or through the stage on the final word
    if (push) begin
      if (last_q) begin
        stage_v_d = 1'b1;
        if (stage_v_q) begin
          out_load = 1'b1;
          out_b_d  = stage_b_q;
        end
      end else begin
        out_load = 1'b1;
      end
    end

    // Decoder step
    if (cmd_i.feed && done) begin
      if (fd_open) begin
        hold_we = 1'b1;
        hold_wa = '0;
        hold_wd = CHAR_AMP;
        cnt_d   = CNT_W'(1);
        match_d = '1;
      end else if (fd_append) begin
        hold_we = 1'b1;
        cnt_d   = cnt_q + CNT_W'(1);
        match_d = keep;
      end else if (fd_hit) begin
        cnt_d = '0;
      end
      if (fd_fail) begin
        rend_d = cnt_q;
        rp_d   = CNT_W'(1);
        cnt_d  = '0;
      end else if (cmd_i.src_replay && !at_tail) begin
        rp_d = rp_q + CNT_W'(1);
      end else begin
        rp_d = '0;
      end
    end

    // Literal flush of held bytes
    if (cmd_i.flush && flush_more && col_done) rp_d = rp_q + CNT_W'(1);

    // Close the text and return to reset state
    if (cmd_i.finish && out_free) begin
      out_load  = 1'b1;
      out_b_d   = stage_v_q ? stage_b_q : CHAR_NUL;
      out_f_d   = stage_v_q;
      out_l_d   = 1'b1;
      cnt_d     = '0;
      lws_d     = 1'b1;
      sp_d      = 1'b0;
      stage_v_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rp_q      <= '0;
      rend_q    <= '0;
      lws_q     <= 1'b1;
      sp_q      <= 1'b0;
      stage_v_q <= 1'b0;
      last_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rp_q      <= rp_d;
      rend_q    <= rend_d;
      lws_q     <= lws_d;
      sp_q      <= sp_d;
      stage_v_q <= stage_v_d;
      if (cmd_i.load) last_q <= in_last_i;
      if (out_load)         ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (cmd_i.load) work_q <= in_byte_i;
    if (hold_we) hold_q[hold_wa[IDX_W-1:0]] <= hold_wd;
    if (cmd_i.feed && done && fd_fail) tail_q <= src;
    if (push && last_q) stage_b_q <= push_byte;
    if (out_load) begin
      ob_q <= out_b_d;
      of_q <= out_f_d;
      ol_q <= out_l_d;
    end
  end

  assign status_o.done       = done;
  assign status_o.fail       = fd_fail;
  assign status_o.at_tail    = at_tail;
  assign status_o.flush_more = flush_more;
  assign status_o.out_free   = out_free;
  assign status_o.last       = last_q;

  assign out_tvalid_o = ov_q;
  assign out_byte_o   = ob_q;
  assign out_flag_o   = of_q;
  assign out_last_o   = ol_q;

endmodule
